FILE: sv/pprp_pkg.sv
// ============================================================================
// pprp_pkg: shared types and codes of the pixel plot, rotate and pack unit
// Holds the register indexes, the depth, order and rotation codes, the
// configuration and pixel structs, and the custom channel packing function.
// ============================================================================
package pprp_pkg;

    // Configuration register indexes, in register file order.
    typedef enum logic [2:0] {
        REG_CANVAS_WIDTH    = 3'd0,
        REG_CANVAS_HEIGHT   = 3'd1,
        REG_LINE_STRIDE     = 3'd2,
        REG_DEPTH_CODE      = 3'd3,
        REG_ROTATION        = 3'd4,
        REG_COLOR_ORDER     = 3'd5,
        REG_CHANNEL_LENGTHS = 3'd6,
        REG_CHANNEL_OFFSETS = 3'd7
    } t_reg_idx;

    localparam int unsigned CfgDataW = 15;

    localparam logic [1:0] DEPTH_16   = 2'd0;
    localparam logic [1:0] DEPTH_24   = 2'd1;
    localparam logic [1:0] DEPTH_32   = 2'd2;
    localparam logic [1:0] DEPTH_NONE = 2'd3;

    localparam logic [1:0] ROT_0   = 2'd0;
    localparam logic [1:0] ROT_90  = 2'd1;
    localparam logic [1:0] ROT_180 = 2'd2;
    localparam logic [1:0] ROT_270 = 2'd3;

    localparam logic [1:0] ORDER_RGB = 2'd0;
    localparam logic [1:0] ORDER_BGR = 2'd1;

    typedef struct packed {
        logic [12:0] canvas_width;
        logic [12:0] canvas_height;
        logic [14:0] line_stride;
        logic [1:0]  depth_code;
        logic [1:0]  rotation;
        logic [1:0]  color_order;
        logic [11:0] channel_lengths;
        logic [14:0] channel_offsets;
    } t_cfg;

    // One pixel after the front stage: framebuffer position, byte count and packed data.
    typedef struct packed {
        logic [12:0] col;
        logic [12:0] row;
        logic [2:0]  bytes;
        logic [31:0] data;
    } t_pix;

    // Custom layout: top len bits of the channel, placed at bit off.
    function automatic logic [31:0] pack_channel(input logic [7:0] c,
                                                 input logic [3:0] len,
                                                 input logic [4:0] off);
        logic [3:0]  len_c;
        logic [3:0]  drop;
        logic [31:0] val;
        len_c = (len > 4'd8) ? 4'd8 : len;
        drop  = 4'd8 - len_c;
        val   = {24'd0, c} >> drop;
        return val << off;
    endfunction

endpackage

FILE: sv/pprp_front.sv
// ============================================================================
// pprp_front: canvas check, rotation and colour packing stage
// Drops pixels outside the canvas or with an unsupported format, maps the
// logical position to a framebuffer column and row, and packs the colour.
// ============================================================================
module pprp_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [7:0]          i_red,
    input  logic [7:0]          i_green,
    input  logic [7:0]          i_blue,
    input  pprp_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output pprp_pkg::t_pix      o_pix
);
    import pprp_pkg::*;

    logic        w_inside;
    logic        w_format_ok;
    logic [12:0] w_x;
    logic [12:0] w_y;
    logic [12:0] w_flip_x;
    logic [12:0] w_flip_y;
    logic [7:0]  w_first;
    logic [7:0]  w_last;
    logic        n_valid;
    t_pix        n_pix;
    logic        r_valid;
    t_pix        r_pix;

    assign w_inside = !i_pos_x[15] && !i_pos_y[15]
                   && (i_pos_x < $signed({3'b000, i_cfg.canvas_width}))
                   && (i_pos_y < $signed({3'b000, i_cfg.canvas_height}));
    assign w_format_ok = (i_cfg.depth_code != DEPTH_NONE)
                      && !(i_cfg.color_order[1] && (i_cfg.depth_code == DEPTH_24));

    // Inside the canvas both coordinates fit the 13-bit canvas range.
    assign w_x      = i_pos_x[12:0];
    assign w_y      = i_pos_y[12:0];
    assign w_flip_x = i_cfg.canvas_width - w_x - 13'd1;
    assign w_flip_y = i_cfg.canvas_height - w_y - 13'd1;

    assign w_first = (i_cfg.color_order == ORDER_RGB) ? i_red : i_blue;
    assign w_last  = (i_cfg.color_order == ORDER_RGB) ? i_blue : i_red;

    always_comb begin
        n_valid = i_valid && w_inside && w_format_ok;
        case (i_cfg.rotation)
            ROT_90: begin
                n_pix.col = w_y;
                n_pix.row = w_flip_x;
            end
            ROT_180: begin
                n_pix.col = w_flip_x;
                n_pix.row = w_flip_y;
            end
            ROT_270: begin
                n_pix.col = w_flip_y;
                n_pix.row = w_x;
            end
            default: begin
                n_pix.col = w_x;
                n_pix.row = w_y;
            end
        endcase
        n_pix.bytes = {1'b0, i_cfg.depth_code} + 3'd2;
        if (!i_cfg.color_order[1]) begin
            if (i_cfg.depth_code == DEPTH_16) begin
                n_pix.data = {16'd0, w_first[7:3], i_green[7:2], w_last[7:3]};
            end else begin
                n_pix.data = {8'd0, w_first, i_green, w_last};
            end
        end else begin
            n_pix.data = pack_channel(i_red, i_cfg.channel_lengths[3:0],
                                      i_cfg.channel_offsets[4:0])
                       | pack_channel(i_green, i_cfg.channel_lengths[7:4],
                                      i_cfg.channel_offsets[9:5])
                       | pack_channel(i_blue, i_cfg.channel_lengths[11:8],
                                      i_cfg.channel_offsets[14:10]);
            if (i_cfg.depth_code == DEPTH_16) begin
                n_pix.data[31:16] = 16'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pix <= n_pix;
    end

    assign o_valid = r_valid;
    assign o_pix   = r_pix;

endmodule

FILE: sv/pprp_addr.sv
// ============================================================================
// pprp_addr: byte offset stages
// Multiplies row by stride and column by bytes per pixel in one stage and
// adds the two products, wrapped to 26 bits, in the next.
// ============================================================================
module pprp_addr (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  pprp_pkg::t_pix  i_pix,
    input  logic [14:0]     i_stride,
    output logic            o_valid,
    output logic [25:0]     o_byte_offset,
    output logic [31:0]     o_write_data,
    output logic [2:0]      o_byte_count
);
    import pprp_pkg::*;

    logic [27:0] w_row_prod;
    logic [15:0] w_col_prod;
    logic        r_valid_m;
    logic [25:0] r_row_prod;
    logic [15:0] r_col_prod;
    logic [31:0] r_data_m;
    logic [2:0]  r_bytes_m;
    logic        r_valid_o;
    logic [25:0] r_offset;
    logic [31:0] r_data_o;
    logic [2:0]  r_bytes_o;

    assign w_row_prod = 28'(i_pix.row) * 28'(i_stride);
    assign w_col_prod = 16'(i_pix.col) * 16'(i_pix.bytes);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_m <= 1'b0;
            r_valid_o <= 1'b0;
        end else begin
            r_valid_m <= i_valid;
            r_valid_o <= r_valid_m;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_prod <= w_row_prod[25:0];
        r_col_prod <= w_col_prod;
        r_data_m   <= i_pix.data;
        r_bytes_m  <= i_pix.bytes;
        r_offset   <= r_row_prod + 26'(r_col_prod);
        r_data_o   <= r_data_m;
        r_bytes_o  <= r_bytes_m;
    end

    assign o_valid       = r_valid_o;
    assign o_byte_offset = r_offset;
    assign o_write_data  = r_data_o;
    assign o_byte_count  = r_bytes_o;

endmodule

FILE: sv/pixel_plot_rotate_pack_unit.sv
// ============================================================================
// pixel_plot_rotate_pack_unit: framebuffer pixel plotter
// Turns one pixel write into a framebuffer byte offset, packed pixel data
// and a byte count, with canvas clipping, rotation and colour packing.
// ============================================================================
// How to use this block:
// An item is a pixel write (pos_x, pos_y, red, green, blue) and is taken at
// a rising edge with start high and busy low. Busy stays low, so one item
// can enter on every clock cycle.
// Each item that lands inside the canvas with a supported depth and colour
// order gives one result on o_byte_offset, o_write_data and o_byte_count,
// marked by o_valid for exactly one cycle. Dropped items give no strobe.
// Throughput is one item per cycle; each result passes three register
// stages: clip/rotate/pack, the two multipliers, and the final add.
// The receiver cannot stall, so every result is taken in its strobe cycle.
// Configuration writes use the i_cfg_valid / o_cfg_ready channel, which is
// always ready; write it only while no item is in flight.
// Synchronous reset (i_rst_n low) empties the pipeline and restores the
// default format: 640 by 480, stride 2560, 32 bit RGB, no rotation.
// ============================================================================
module pixel_plot_rotate_pack_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  i_pos_x,
    input  logic signed [15:0]  i_pos_y,
    input  logic [7:0]          i_red_in,
    input  logic [7:0]          i_green_in,
    input  logic [7:0]          i_blue_in,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [pprp_pkg::CfgDataW-1:0] i_cfg_data,
    output logic                o_valid,
    output logic [25:0]         o_byte_offset,
    output logic [31:0]         o_write_data,
    output logic [2:0]          o_byte_count
);
    import pprp_pkg::*;

    t_cfg     r_cfg;
    t_cfg     n_cfg;
    t_reg_idx w_index;
    logic     w_accept;
    logic     w_front_valid;
    t_pix     w_front_pix;

    // The pipeline takes an item every cycle and the register file takes a
    // write every cycle, so neither side ever pushes back.
    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_index     = t_reg_idx'(i_cfg_index);

    // Register file write decode. Each register keeps only its own width.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid && o_cfg_ready) begin
            unique case (w_index)
                REG_CANVAS_WIDTH:    n_cfg.canvas_width    = i_cfg_data[12:0];
                REG_CANVAS_HEIGHT:   n_cfg.canvas_height   = i_cfg_data[12:0];
                REG_LINE_STRIDE:     n_cfg.line_stride     = i_cfg_data[14:0];
                REG_DEPTH_CODE:      n_cfg.depth_code      = i_cfg_data[1:0];
                REG_ROTATION:        n_cfg.rotation        = i_cfg_data[1:0];
                REG_COLOR_ORDER:     n_cfg.color_order     = i_cfg_data[1:0];
                REG_CHANNEL_LENGTHS: n_cfg.channel_lengths = i_cfg_data[11:0];
                REG_CHANNEL_OFFSETS: n_cfg.channel_offsets = i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.canvas_width    <= 13'd640;
            r_cfg.canvas_height   <= 13'd480;
            r_cfg.line_stride     <= 15'd2560;
            r_cfg.depth_code      <= DEPTH_32;
            r_cfg.rotation        <= ROT_0;
            r_cfg.color_order     <= ORDER_RGB;
            r_cfg.channel_lengths <= 12'd1416;
            r_cfg.channel_offsets <= 15'd352;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // First stage: clipping, format check, rotation and colour packing.
    pprp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_pos_x (i_pos_x),
        .i_pos_y (i_pos_y),
        .i_red   (i_red_in),
        .i_green (i_green_in),
        .i_blue  (i_blue_in),
        .i_cfg   (r_cfg),
        .o_valid (w_front_valid),
        .o_pix   (w_front_pix)
    );

    // Second and third stages: the offset products and their sum.
    pprp_addr u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_front_valid),
        .i_pix         (w_front_pix),
        .i_stride      (r_cfg.line_stride),
        .o_valid       (o_valid),
        .o_byte_offset (o_byte_offset),
        .o_write_data  (o_write_data),
        .o_byte_count  (o_byte_count)
    );

`ifndef SYNTHESIS
    // Reset empties the pipeline, so no result strobe follows a reset cycle.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");

    // Only the three supported depths ever reach the output.
    a_count_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_byte_count == 3'd2 || o_byte_count == 3'd3
                     || o_byte_count == 3'd4))
        else $error("illegal byte count on a result");

    // Data bits beyond the written bytes must be clear.
    a_data_16: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_count == 3'd2) |-> (o_write_data[31:16] == 16'd0))
        else $error("16 bit pixel carries high data bits");

    a_data_24: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_byte_count == 3'd3) |-> (o_write_data[31:24] == 8'd0))
        else $error("24 bit pixel carries high data bits");
`endif

endmodule
